[src/ita_pkg.sv]
// Shared types, codes and the digit-to-ASCII function for the integer to ASCII formatter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ita_pkg;

  // Number of digit cells in the chain; enough for a 64-bit value in hex.
  localparam int unsigned NumCells = 16;

  // Width of the remaining-digit and character counters.
  localparam int unsigned CntW = 5;

  // Format codes carried on the opcode field.
  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEXL = 3'd2,
    OP_HEXU = 3'd3,
    OP_PTR  = 3'd4
  } op_e;

  // Operation applied to all cells of the chain in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_DABBLE = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_e;

  // ASCII characters used outside the digit set.
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrX     = 8'h78;

  // Maps one digit to its ASCII code, in upper or lower case for the letters.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      base = ChrZero;
    end else if (upper) begin
      base = 8'h37;
    end else begin
      base = 8'h57;
    end
    return base + {4'h0, d};
  endfunction

endpackage

`default_nettype wire

[src/ita_cell.sv]
// One digit cell of the conversion chain: holds a 4-bit digit, loads it, shifts it
// to the next cell up, or takes one double-dabble step. Depends on ita_pkg.
`default_nettype none

module ita_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ita_pkg::cell_op_e op_i,
  input  wire logic [3:0]        load_i,
  input  wire logic              bit_i,
  input  wire logic [3:0]        digit_i,
  output logic [3:0]             digit_o,
  output logic                   carry_o
);
  import ita_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add three to digits of five and above before the doubling step.
  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  // Next digit for the chain operation of this cycle.
  always_comb begin
    case (op_i)
      CELL_LOAD:   digit_d = load_i;
      CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  // Digit register; it starts from zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

[src/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: control sequencer, magnitude register,
// chain of ita_cell digit cells and output register. Depends on ita_pkg and ita_cell.
`default_nettype none

// Takes one number per input beat and sends its text, most significant character first,
// as one output beat per character; the final beat carries last and the character count.
// One number is handled at a time. After the input beat, a decimal number goes through the
// double-dabble pass in the sixteen-cell digit chain, one magnitude bit per cycle; every
// format then shifts out up to 15 leading zero cells and sends its characters, advancing
// only while the output side is ready. Opcodes 5 to 7 are taken and give no output.
module integer_to_ascii_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] value_i,
  input  wire logic [2:0]  opcode_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       character_o,
  output logic             last_o,
  output logic [4:0]       char_count_o
);
  import ita_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_PFX  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [31:0]       mag_q;
  logic [4:0]        bitcnt_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              pfx_idx_q;
  logic              neg_q;
  logic              upper_q;
  logic              ptr_q;

  logic              out_valid_q;
  logic [7:0]        char_q;
  logic              last_q;
  logic [CntW-1:0]   count_q;

  logic              accept;
  logic              op_valid;
  logic              op_dec;
  logic              adv;
  logic [31:0]       low;
  logic              neg_in;
  cell_op_e          cell_op;
  logic [3:0]        load_val [NumCells];
  logic [3:0]        digit    [NumCells];
  logic              carry    [NumCells];
  logic [3:0]        top;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign adv         = !out_valid_q || out_ready_i;
  assign low         = value_i[31:0];
  assign top         = digit[NumCells-1];

  // Decode the incoming format code.
  always_comb begin
    op_valid = 1'b1;
    op_dec   = 1'b0;
    case (opcode_i)
      OP_SDEC, OP_UDEC: op_dec = 1'b1;
      OP_HEXL, OP_HEXU, OP_PTR: op_dec = 1'b0;
      default: op_valid = 1'b0;
    endcase
  end

  assign neg_in = (opcode_i == OP_SDEC) && low[31];

  // Parallel load values: nibbles for hex, a cleared chain for decimal.
  for (genvar i = 0; i < NumCells; i++) begin : g_load
    always_comb begin
      if (op_dec || ((opcode_i != OP_PTR) && (i >= NumCells / 2))) begin
        load_val[i] = 4'h0;
      end else begin
        load_val[i] = value_i[4*i +: 4];
      end
    end
  end

  // Chain operation for this cycle.
  always_comb begin
    cell_op = CELL_HOLD;
    case (state_q)
      ST_IDLE: if (accept && op_valid) cell_op = CELL_LOAD;
      ST_CONV: cell_op = CELL_DABBLE;
      ST_SKIP: if ((top == 4'h0) && (rem_q > 5'd1)) cell_op = CELL_SHIFT;
      ST_EMIT: if (adv) cell_op = CELL_SHIFT;
      default: cell_op = CELL_HOLD;
    endcase
  end

  // The digit chain; cell zero is the least significant digit.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] dig_in;
    if (i == 0) begin : g_first
      assign bit_in = mag_q[31];
      assign dig_in = 4'h0;
    end else begin : g_rest
      assign bit_in = carry[i-1];
      assign dig_in = digit[i-1];
    end
    ita_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .load_i  (load_val[i]),
      .bit_i   (bit_in),
      .digit_i (dig_in),
      .digit_o (digit[i]),
      .carry_o (carry[i])
    );
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && op_valid) state_d = op_dec ? ST_CONV : ST_SKIP;
      end
      ST_CONV: begin
        if (bitcnt_q == 5'd31) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!((top == 4'h0) && (rem_q > 5'd1))) state_d = (neg_q || ptr_q) ? ST_PFX : ST_EMIT;
      end
      ST_PFX: begin
        if (adv && (!ptr_q || pfx_idx_q)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (adv && (rem_q == 5'd1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bitcnt_q    <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      pfx_idx_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        bitcnt_q  <= '0;
        rem_q     <= CntW'(NumCells);
        cnt_q     <= '0;
        pfx_idx_q <= 1'b0;
      end
      if (state_q == ST_CONV) bitcnt_q <= bitcnt_q + 5'd1;
      if ((cell_op == CELL_SHIFT) && (rem_q > 5'd1)) rem_q <= rem_q - 5'd1;
      if (((state_q == ST_PFX) || (state_q == ST_EMIT)) && adv) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 5'd1;
        if (state_q == ST_PFX) pfx_idx_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Number payload: magnitude for the decimal pass and format flags.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q   <= neg_in ? (32'd0 - low) : low;
      neg_q   <= neg_in;
      upper_q <= (opcode_i == OP_HEXU);
      ptr_q   <= (opcode_i == OP_PTR);
    end else if (state_q == ST_CONV) begin
      mag_q <= {mag_q[30:0], 1'b0};
    end
  end

  // Output register: one character per beat.
  always_ff @(posedge clk_i) begin
    if (adv && (state_q == ST_PFX)) begin
      char_q  <= ptr_q ? (pfx_idx_q ? ChrX : ChrZero) : ChrMinus;
      last_q  <= 1'b0;
      count_q <= '0;
    end else if (adv && (state_q == ST_EMIT)) begin
      char_q  <= digit_char(top, upper_q);
      last_q  <= (rem_q == 5'd1);
      count_q <= (rem_q == 5'd1) ? (cnt_q + 5'd1) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign character_o  = char_q;
  assign last_o       = last_q;
  assign char_count_o = count_q;

  // A final beat always carries a non-zero count.
  a_last_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (char_count_o != 5'd0))
    else $error("final beat with zero count");

  // Earlier beats carry no count.
  a_mid_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (char_count_o == 5'd0))
    else $error("count on a non-final beat");

  // A 32-bit decimal value never reaches the top cell during conversion.
  a_conv_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (top == 4'h0))
    else $error("decimal conversion overflowed the digit chain");

  // Digit emission never runs with no digits left.
  a_emit_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != 5'd0))
    else $error("emission with no remaining digits");

  // The input stays closed after a digit that is not the last one is sent.
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && adv && rem_q != 5'd1) |=> !in_ready_o)
    else $error("input taken mid-number");

endmodule

`default_nettype wire
